/* rtl/byte_stuffed_frame_receiver_core_assert.svh */
// Assertion macros for the checker file of the frame receiver.
// Needs a clock named clock and a synchronous reset named reset in scope.
`ifndef BYTE_STUFFED_FRAME_RECEIVER_CORE_ASSERT_SVH
`define BYTE_STUFFED_FRAME_RECEIVER_CORE_ASSERT_SVH

// same-cycle implication
`define BSFR_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("frame receiver check failed");

// next-cycle implication
`define BSFR_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("frame receiver check failed");

`endif

/* rtl/bsfr_pkg.sv */
// Package for the byte-stuffed frame receiver: widths, register indexes,
// reset values and the config and result structs. No dependencies.
package bsfr_pkg;

   localparam int unsigned ByteW = 8;

   typedef enum logic [1:0] {
      CSR_FLAG_BYTE   = 2'd0,
      CSR_ESCAPE_BYTE = 2'd1,
      CSR_ESCAPE_MASK = 2'd2,
      CSR_MAX_LEN     = 2'd3
   } csr_idx_type;

   localparam logic [ByteW-1:0] FlagReset   = 8'h7E;
   localparam logic [ByteW-1:0] EscapeReset = 8'h7D;
   localparam logic [ByteW-1:0] MaskReset   = 8'h20;
   localparam logic [ByteW-1:0] MaxLenReset = 8'd40;

   typedef struct packed {
      logic [ByteW-1:0] flag_byte;
      logic [ByteW-1:0] escape_byte;
      logic [ByteW-1:0] escape_mask;
      logic [ByteW-1:0] max_frame_len;
   } cfg_type;

   typedef struct packed {
      logic [ByteW-1:0] out_byte;
      logic             is_first;
      logic             is_last;
      logic             overflow;
      logic             frame_error;
   } result_type;

endpackage

/* rtl/bsfr_csr.sv */
// Configuration registers of the frame receiver.
// Depends on bsfr_pkg.
module bsfr_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_addr,
   input  logic [bsfr_pkg::ByteW-1:0]      csr_wdata,
   output bsfr_pkg::cfg_type               cfg
);

   bsfr_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (bsfr_pkg::csr_idx_type'(csr_addr))
            bsfr_pkg::CSR_FLAG_BYTE:   cfg_in.flag_byte     = csr_wdata;
            bsfr_pkg::CSR_ESCAPE_BYTE: cfg_in.escape_byte   = csr_wdata;
            bsfr_pkg::CSR_ESCAPE_MASK: cfg_in.escape_mask   = csr_wdata;
            bsfr_pkg::CSR_MAX_LEN:     cfg_in.max_frame_len = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flag_byte     <= bsfr_pkg::FlagReset;
         cfg_ff.escape_byte   <= bsfr_pkg::EscapeReset;
         cfg_ff.escape_mask   <= bsfr_pkg::MaskReset;
         cfg_ff.max_frame_len <= bsfr_pkg::MaxLenReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/bsfr_deframe.sv */
// Input register, frame state and per-byte deframing/unescape logic.
// Depends on bsfr_pkg.
module bsfr_deframe (
   input  logic                       clock,
   input  logic                       reset,
   input  bsfr_pkg::cfg_type          cfg,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [bsfr_pkg::ByteW-1:0] req_tdata,
   input  logic                       out_space,
   output logic                       res_valid,
   output bsfr_pkg::result_type       res
);

   logic                       in_valid_ff, in_valid_in;
   logic [bsfr_pkg::ByteW-1:0] in_byte_ff;
   logic                       in_frame_ff, in_frame_in;
   logic                       esc_ff, esc_in;
   logic [bsfr_pkg::ByteW-1:0] count_ff, count_in;
   logic                       ovfd_ff, ovfd_in;
   logic                       advance, is_flag, emit;
   logic [bsfr_pkg::ByteW-1:0] data;
   logic [bsfr_pkg::ByteW:0]   count_next;

   assign advance     = in_valid_ff && out_space;
   assign req_tready  = !in_valid_ff || out_space;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;
   assign is_flag     = (in_byte_ff == cfg.flag_byte);
   assign count_next  = {1'b0, count_ff} + 1'b1;

   always_comb begin
      in_frame_in = in_frame_ff;
      esc_in      = esc_ff;
      count_in    = count_ff;
      ovfd_in     = ovfd_ff;
      emit        = 1'b0;
      res         = '0;
      data        = in_byte_ff;
      if (!in_frame_ff) begin
         // hunting: only a flag opens a frame
         if (is_flag) begin
            in_frame_in  = 1'b1;
            esc_in       = 1'b0;
            count_in     = 8'd1;
            ovfd_in      = 1'b0;
            emit         = 1'b1;
            res.out_byte = in_byte_ff;
            res.is_first = 1'b1;
         end
      end else if (is_flag) begin
         // back-to-back flag right after the opener is swallowed
         if (!(count_ff == 8'd1 && !esc_ff && !ovfd_ff)) begin
            emit            = 1'b1;
            res.out_byte    = in_byte_ff;
            res.is_last     = 1'b1;
            res.overflow    = ovfd_ff || (count_ff >= cfg.max_frame_len);
            res.frame_error = esc_ff;
            in_frame_in     = 1'b0;
            esc_in          = 1'b0;
            count_in        = '0;
            ovfd_in         = 1'b0;
         end
      end else if (!esc_ff && in_byte_ff == cfg.escape_byte) begin
         esc_in = 1'b1;
      end else begin
         if (esc_ff) begin
            data   = in_byte_ff ^ cfg.escape_mask;
            esc_in = 1'b0;
         end
         // keep room for the closing flag
         if (count_next < {1'b0, cfg.max_frame_len}) begin
            count_in     = count_next[bsfr_pkg::ByteW-1:0];
            emit         = 1'b1;
            res.out_byte = data;
         end else begin
            ovfd_in = 1'b1;
         end
      end
   end

   assign res_valid = advance && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         in_frame_ff <= 1'b0;
         esc_ff      <= 1'b0;
         count_ff    <= '0;
         ovfd_ff     <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            in_frame_ff <= in_frame_in;
            esc_ff      <= esc_in;
            count_ff    <= count_in;
            ovfd_ff     <= ovfd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

endmodule

/* rtl/bsfr_out.sv */
// Result register feeding the rsp stream.
// Depends on bsfr_pkg.
module bsfr_out (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       res_valid,
   input  bsfr_pkg::result_type       res,
   output logic                       out_space,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [bsfr_pkg::ByteW-1:0] rsp_tdata,
   output logic                       rsp_tlast,
   output logic [2:0]                 rsp_tuser
);

   logic                 valid_ff, valid_in;
   bsfr_pkg::result_type res_ff;

   assign out_space = !valid_ff || rsp_tready;
   assign valid_in  = res_valid || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = res_ff.out_byte;
   assign rsp_tlast  = res_ff.is_last;
   assign rsp_tuser  = {res_ff.frame_error, res_ff.overflow, res_ff.is_first};

endmodule

/* rtl/byte_stuffed_frame_receiver_core.sv */
// Byte-stuffed frame receiver core: top level.
// Depends on bsfr_pkg, bsfr_csr, bsfr_deframe and bsfr_out.
//
// Usage:
//  - req channel carries one raw link byte per beat in req_tdata.
//  - rsp channel carries one frame byte per beat, already unescaped.
//    Opening flag has rsp_tuser[0] set, closing flag has rsp_tlast set and
//    reports overflow (rsp_tuser[1]) and escape-before-flag (rsp_tuser[2]).
//  - Bytes outside a frame, escapes and bytes past max_frame_len give no beat.
//  - csr_* writes flag, escape, mask, length limit; only with no beat in flight.
// Timing:
//  - A req beat is loaded into the input register on accept and then into the
//    result register, whose valid drives rsp_tvalid.
//  - Throughput is one byte per cycle while rsp_tready stays high; the single
//    state update per byte (compares, one XOR, one 9-bit increment) sets the cycle.
//  - When rsp_tready is low the result register holds its beat; the input
//    register keeps taking a beat while it is empty or the result register is
//    free or draining, else req_tready drops.
// Reset: clears pipeline valids and frame state (hunting); defaults hex 7E, 7D, 20, 28.
module byte_stuffed_frame_receiver_core (
   input  logic                       clock,
   input  logic                       reset,
   // config write port
   input  logic                       csr_we,
   input  logic [1:0]                 csr_addr,
   input  logic [bsfr_pkg::ByteW-1:0] csr_wdata,
   // req stream
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [bsfr_pkg::ByteW-1:0] req_tdata,   // [7:0] rx_byte
   // rsp stream
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [bsfr_pkg::ByteW-1:0] rsp_tdata,   // [7:0] out_byte
   output logic                       rsp_tlast,   // is_last
   output logic [2:0]                 rsp_tuser    // [0] is_first, [1] overflow,
                                                   // [2] frame_error
);

   bsfr_pkg::cfg_type    cfg;
   bsfr_pkg::result_type res;
   logic                 res_valid;
   logic                 out_space;

   bsfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // per-beat deframe/unescape, state updated only as a beat advances
   bsfr_deframe u_deframe (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .out_space  (out_space),
      .res_valid  (res_valid),
      .res        (res)
   );

   bsfr_out u_out (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res        (res),
      .out_space  (out_space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* rtl/bsfr_checker.sv */
// Port-level checks for the frame receiver, bound to the top level.
// Depends on byte_stuffed_frame_receiver_core_assert.svh.
`include "byte_stuffed_frame_receiver_core_assert.svh"

module bsfr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [2:0] rsp_tuser
);

   // stalled beat holds
   `BSFR_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // a beat cannot both open and close a frame
   `BSFR_ASSERT_IMP(a_first_not_last, rsp_tvalid && rsp_tuser[0], !rsp_tlast)

   // status bits appear only on the closing beat
   `BSFR_ASSERT_IMP(a_status_on_last, rsp_tvalid && !rsp_tlast, rsp_tuser[2:1] == 2'b00)

   // nothing comes out the cycle after reset is released
   `BSFR_ASSERT_IMP(a_quiet_after_reset, $fell(reset), !rsp_tvalid)

endmodule

bind byte_stuffed_frame_receiver_core bsfr_checker u_bsfr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
